// File: rtl/core/pcc_pkg.sv
// pcc_pkg: types, constants and arctangent table for the polar/Cartesian converter.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int COORD_W   = 16;
    localparam int RAD_W     = COORD_W - 1;
    localparam int ANG_W     = 16;
    localparam int GUARD     = 8;
    localparam int DW        = COORD_W + GUARD + 3;
    localparam int ZW        = 25;
    localparam int TABLE_LEN = 24;
    localparam int GAIN_W    = 30;
    localparam int PROD_W    = DW + GAIN_W;
    localparam int Q_W       = PROD_W - 38;
    localparam int V_W       = Q_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_Q30     = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_TURN    = 25'sh0800000;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 25'sh0400000;

    typedef enum logic
    {
        OP_TO_POLAR = 1'b0,
        OP_TO_RECT  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                       op;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [RAD_W-1:0]          radius_in;
        logic [ANG_W-1:0]          angle_in;
    } in_word_t;

    typedef struct packed
    {
        logic [COORD_W-1:0]        radius_out;
        logic [ANG_W-1:0]          angle_out;
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
    } out_word_t;

    typedef struct packed
    {
        logic                 valid;
        op_t                  op;
        logic                 zero;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RAD_W-1:0]     radius;
        logic [ANG_W-1:0]     angle;
    } cordic_t;

    typedef struct packed
    {
        op_t              op;
        logic             zero;
        logic [RAD_W-1:0] radius;
        logic [ANG_W-1:0] angle;
    } gain_meta_t;

    // round(atan(2^-i) / (2*pi) * 2^24)
    function automatic logic [ZW-1:0] atan_entry(input int idx);
        logic [ZW-1:0] val;
        case (idx)
            0:       val = 25'd2097152;
            1:       val = 25'd1238021;
            2:       val = 25'd654136;
            3:       val = 25'd332050;
            4:       val = 25'd166669;
            5:       val = 25'd83416;
            6:       val = 25'd41718;
            7:       val = 25'd20860;
            8:       val = 25'd10430;
            9:       val = 25'd5215;
            10:      val = 25'd2608;
            11:      val = 25'd1304;
            12:      val = 25'd652;
            13:      val = 25'd326;
            14:      val = 25'd163;
            15:      val = 25'd81;
            16:      val = 25'd41;
            17:      val = 25'd20;
            18:      val = 25'd10;
            19:      val = 25'd5;
            20:      val = 25'd3;
            21:      val = 25'd1;
            22:      val = 25'd1;
            default: val = 25'd0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/core/pcc_prep.sv
// pcc_prep: input decode and quadrant pre-rotation, one register stage.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_prep
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pcc_pkg::in_word_t operand,
    output pcc_pkg::cordic_t  prep_out
);

    localparam int DW  = pcc_pkg::DW;
    localparam int ZW  = pcc_pkg::ZW;
    localparam int CW  = pcc_pkg::COORD_W;
    localparam int EXT = DW - CW;

    logic                 valid_reg;
    pcc_pkg::cordic_t     data_reg;
    pcc_pkg::cordic_t     data_next;
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    logic signed [DW-1:0] rx;
    logic signed [ZW-1:0] za;

    always_comb
    begin
        cx = {{EXT{operand.coord_x[CW-1]}}, operand.coord_x};
        cy = {{EXT{operand.coord_y[CW-1]}}, operand.coord_y};
        rx = DW'({operand.radius_in, {pcc_pkg::GUARD{1'b0}}});
        za = {operand.angle_in[pcc_pkg::ANG_W-1], operand.angle_in, 8'b0};

        data_next        = '0;
        data_next.valid  = 1'b1;
        data_next.op     = operand.op;
        data_next.radius = operand.radius_in;
        data_next.angle  = operand.angle_in;

        if (operand.op == pcc_pkg::OP_TO_POLAR)
        begin
            data_next.zero = (cx == '0) && (cy == '0);
            if (cx[DW-1])
            begin
                data_next.x = (-cx) <<< pcc_pkg::GUARD;
                data_next.y = (-cy) <<< pcc_pkg::GUARD;
                data_next.z = pcc_pkg::HALF_TURN;
            end
            else
            begin
                data_next.x = cx <<< pcc_pkg::GUARD;
                data_next.y = cy <<< pcc_pkg::GUARD;
                data_next.z = '0;
            end
        end
        else
        begin
            data_next.y = '0;
            if (za > pcc_pkg::QUARTER_TURN)
            begin
                data_next.x = -rx;
                data_next.z = za - pcc_pkg::HALF_TURN;
            end
            else if (za < -pcc_pkg::QUARTER_TURN)
            begin
                data_next.x = -rx;
                data_next.z = za + pcc_pkg::HALF_TURN;
            end
            else
            begin
                data_next.x = rx;
                data_next.z = za;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        prep_out       = data_reg;
        prep_out.valid = valid_reg;
    end

endmodule

// File: rtl/core/pcc_stage.sv
// pcc_stage: one registered CORDIC micro-rotation, vectoring or rotation by op.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_stage
#(
    parameter int SHIFT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pcc_pkg::cordic_t stage_in,
    output pcc_pkg::cordic_t stage_out
);

    localparam int DW = pcc_pkg::DW;
    localparam int ZW = pcc_pkg::ZW;
    localparam logic signed [ZW-1:0] ATAN = pcc_pkg::atan_entry(SHIFT);

    logic                 valid_reg;
    pcc_pkg::cordic_t     data_reg;
    pcc_pkg::cordic_t     data_next;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic                 ccw;

    always_comb
    begin
        xs  = stage_in.x >>> SHIFT;
        ys  = stage_in.y >>> SHIFT;
        // rotation: turn toward z = 0; vectoring: turn toward y = 0
        ccw = (stage_in.op == pcc_pkg::OP_TO_RECT) ? !stage_in.z[ZW-1] : stage_in.y[DW-1];

        data_next = stage_in;
        if (ccw)
        begin
            data_next.x = stage_in.x - ys;
            data_next.y = stage_in.y + xs;
            data_next.z = (stage_in.op == pcc_pkg::OP_TO_RECT) ?
                          stage_in.z - ATAN : stage_in.z - ATAN;
        end
        else
        begin
            data_next.x = stage_in.x + ys;
            data_next.y = stage_in.y - xs;
            data_next.z = stage_in.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// File: rtl/core/pcc_gain.sv
// pcc_gain: gain correction (abs, Q30 multiply, round and saturate), three stages.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_gain
(
    input  logic               clk,
    input  logic               rst_n,
    input  pcc_pkg::cordic_t   gain_in,
    output logic               done,
    output pcc_pkg::out_word_t result
);

    localparam int DW     = pcc_pkg::DW;
    localparam int CW     = pcc_pkg::COORD_W;
    localparam int PROD_W = pcc_pkg::PROD_W;
    localparam int Q_W    = pcc_pkg::Q_W;
    localparam int V_W    = pcc_pkg::V_W;
    localparam logic [PROD_W-1:0]     RND     = PROD_W'(1) << 37;
    localparam logic signed [V_W-1:0] SAT_HI  = V_W'((1 << (CW - 1)) - 1);
    localparam logic signed [V_W-1:0] SAT_LO  = -SAT_HI - V_W'(1);
    localparam logic [Q_W-1:0]        MAG_MAX = Q_W'((1 << CW) - 1);

    logic                s1_valid_reg;
    pcc_pkg::gain_meta_t s1_meta_reg;
    pcc_pkg::gain_meta_t s1_meta_next;
    logic [DW-1:0]       s1_ax_reg;
    logic [DW-1:0]       s1_ay_reg;
    logic                s1_sx_reg;
    logic                s1_sy_reg;

    logic                s2_valid_reg;
    pcc_pkg::gain_meta_t s2_meta_reg;
    logic [PROD_W-1:0]   s2_px_reg;
    logic [PROD_W-1:0]   s2_py_reg;
    logic                s2_sx_reg;
    logic                s2_sy_reg;

    logic                done_reg;
    pcc_pkg::out_word_t  result_reg;
    pcc_pkg::out_word_t  result_next;

    logic [PROD_W-1:0]    rx;
    logic [PROD_W-1:0]    ry;
    logic [Q_W-1:0]       qx;
    logic [Q_W-1:0]       qy;
    logic signed [V_W-1:0] vx;
    logic signed [V_W-1:0] vy;
    logic [23:0]          zr;

    // stage 1: magnitudes and output angle
    always_comb
    begin
        zr = gain_in.z[23:0] + 24'd128;
        s1_meta_next        = '0;
        s1_meta_next.op     = gain_in.op;
        s1_meta_next.zero   = gain_in.zero;
        s1_meta_next.radius = gain_in.radius;
        s1_meta_next.angle = (gain_in.op == pcc_pkg::OP_TO_RECT) ? gain_in.angle : zr[23:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= gain_in.valid;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gain_in.valid)
        begin
            s1_meta_reg <= s1_meta_next;
            s1_ax_reg <= gain_in.x[DW-1] ? DW'(-gain_in.x) : DW'(gain_in.x);
            s1_ay_reg <= gain_in.y[DW-1] ? DW'(-gain_in.y) : DW'(gain_in.y);
            s1_sx_reg <= gain_in.x[DW-1];
            s1_sy_reg <= gain_in.y[DW-1];
        end
    end

    // stage 2: Q30 gain multiply
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_px_reg <= PROD_W'(s1_ax_reg) * PROD_W'(pcc_pkg::GAIN_Q30);
            s2_py_reg <= PROD_W'(s1_ay_reg) * PROD_W'(pcc_pkg::GAIN_Q30);
            s2_sx_reg <= s1_sx_reg;
            s2_sy_reg <= s1_sy_reg;
        end
    end

    // stage 3: round half away from zero, drop guard bits, saturate
    always_comb
    begin
        rx = s2_px_reg + RND;
        ry = s2_py_reg + RND;
        qx = rx[PROD_W-1:38];
        qy = ry[PROD_W-1:38];
        vx = s2_sx_reg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        vy = s2_sy_reg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

        result_next = '0;
        if (s2_meta_reg.op == pcc_pkg::OP_TO_RECT)
        begin
            result_next.radius_out = CW'(s2_meta_reg.radius);
            result_next.angle_out  = s2_meta_reg.angle;
            result_next.x_out = (vx > SAT_HI) ? CW'(SAT_HI) :
                                (vx < SAT_LO) ? CW'(SAT_LO) : CW'(vx);
            result_next.y_out = (vy > SAT_HI) ? CW'(SAT_HI) :
                                (vy < SAT_LO) ? CW'(SAT_LO) : CW'(vy);
        end
        else if (!s2_meta_reg.zero)
        begin
            result_next.angle_out  = s2_meta_reg.angle;
            result_next.radius_out = s2_sx_reg ? '0 :
                                     (qx > MAG_MAX) ? CW'(MAG_MAX) : CW'(qx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/polar_cartesian_convert_unit.sv
// polar_cartesian_convert_unit: pipelined CORDIC converter, Cartesian <-> polar.
// Pipeline: one prep stage, one stage per CORDIC step, three gain stages. Throughput
// one word per cycle; busy stays low.
// Reset clears only the valid bits of the pipeline; done is low after reset.
// Depends on pcc_pkg, pcc_prep, pcc_stage, pcc_gain.
`timescale 1ns / 1ps

module polar_cartesian_convert_unit
#(
    parameter int ITERATIONS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pcc_pkg::in_word_t  operand,
    output logic               done,
    output pcc_pkg::out_word_t result
);

    localparam int NSTAGE = (ITERATIONS > pcc_pkg::TABLE_LEN) ?
                            pcc_pkg::TABLE_LEN : ITERATIONS;

    pcc_pkg::cordic_t pipe [0:NSTAGE];

    assign busy = 1'b0;

    pcc_prep u_prep
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operand  (operand),
        .prep_out (pipe[0])
    );

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_stage
        pcc_stage
        #(
            .SHIFT (i)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (pipe[i]),
            .stage_out (pipe[i+1])
        );
    end

    pcc_gain u_gain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .gain_in (pipe[NSTAGE]),
        .done    (done),
        .result  (result)
    );

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for polar_cartesian_convert_unit, both conversion directions.
// Directed table then random words, scored against a bit-exact CORDIC predictor or fixed expected words.
// Depends on pcc_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;

    localparam int ITER          = 16;
    localparam int LATENCY       = ITER + 4;
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_WORDS  = 1330;
    localparam int IDLE_PCT      = 17;
    localparam int MAX_REPORTS   = 10;

    localparam longint HALF    = longint'(pcc_pkg::HALF_TURN);
    localparam longint QUARTER = longint'(pcc_pkg::QUARTER_TURN);
    localparam longint COORD_HI = 32767;
    localparam longint COORD_LO = -32768;
    localparam longint unsigned GAIN_HI = longint'(pcc_pkg::GAIN_Q30) >> 15;
    localparam longint unsigned GAIN_LO = longint'(pcc_pkg::GAIN_Q30) & 64'h7FFF;

    typedef struct packed
    {
        logic               typed;
        pcc_pkg::in_word_t  stim;
        pcc_pkg::out_word_t res;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    pcc_pkg::in_word_t  operand;
    logic               done;
    pcc_pkg::out_word_t result;

    pcc_pkg::out_word_t pending_results[$];
    int                 mismatch_count;
    plan_row_t          plan [DIRECTED_ROWS];

    // atan(2^-i) in 2^24 units per turn
    longint atan_step [pcc_pkg::TABLE_LEN] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    polar_cartesian_convert_unit #(.ITERATIONS(ITER)) uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Q30 gain multiply, magnitude rounded half away from zero, guard bits dropped
    function automatic longint scale_by_gain(input longint v);
        longint unsigned m;
        longint unsigned pa;
        longint unsigned pb;
        longint unsigned q;
        longint unsigned t;
        m  = (v < 0) ? longint'(-v) : longint'(v);
        pa = m * GAIN_HI;
        pb = m * GAIN_LO;
        q  = pa >> 23;
        t  = ((pa & 64'h7FFFFF) << 15) + pb + (64'd1 << 37);
        q  = q + (t >> 38);
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_coord(input longint v);
        return (v > COORD_HI) ? COORD_HI : ((v < COORD_LO) ? COORD_LO : v);
    endfunction

    function automatic pcc_pkg::out_word_t convert_word(input pcc_pkg::in_word_t w);
        pcc_pkg::out_word_t o;
        longint    x;
        longint    y;
        longint    z;
        longint    nx;
        longint    ny;
        longint    mag;
        longint    zu;
        int        i;
        o = '0;
        if (w.op == pcc_pkg::OP_TO_POLAR)
        begin
            x = longint'($signed(w.coord_x));
            y = longint'($signed(w.coord_y));
            if (x == 0 && y == 0)
                return o;
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF;
            end
            x = x <<< pcc_pkg::GUARD;
            y = y <<< pcc_pkg::GUARD;
            for (i = 0; i < ITER && i < pcc_pkg::TABLE_LEN; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + atan_step[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - atan_step[i];
                end
                x = nx;
                y = ny;
            end
            mag = scale_by_gain(x);
            if (mag < 0)
                mag = 0;
            if (mag > 65535)
                mag = 65535;
            zu = z & 64'hFFFFFF;
            o.radius_out = mag[15:0];
            o.angle_out  = 16'((zu + 128) >> 8);
        end
        else
        begin
            o.radius_out = {1'b0, w.radius_in};
            o.angle_out  = w.angle_in;
            z = longint'(w.angle_in) << 8;
            if (z >= HALF)
                z = z - 2 * HALF;
            x = longint'(w.radius_in) << pcc_pkg::GUARD;
            y = 0;
            if (z > QUARTER)
            begin
                x = -x;
                z = z - HALF;
            end
            else if (z < -QUARTER)
            begin
                x = -x;
                z = z + HALF;
            end
            for (i = 0; i < ITER && i < pcc_pkg::TABLE_LEN; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - atan_step[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + atan_step[i];
                end
                x = nx;
                y = ny;
            end
            o.x_out = 16'(clamp_coord(scale_by_gain(x)));
            o.y_out = 16'(clamp_coord(scale_by_gain(y)));
        end
        return o;
    endfunction

    function automatic plan_row_t row(input pcc_pkg::op_t op, input logic [15:0] cx,
                                      input logic [15:0] cy, input logic [14:0] r,
                                      input logic [15:0] a, input logic typed,
                                      input pcc_pkg::out_word_t res);
        plan_row_t p;
        p.typed          = typed;
        p.stim.op        = op;
        p.stim.coord_x   = cx;
        p.stim.coord_y   = cy;
        p.stim.radius_in = r;
        p.stim.angle_in  = a;
        p.res            = res;
        return p;
    endfunction

    function automatic logic [15:0] random_coord();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'($urandom);
            4, 5:       v = 16'($signed($urandom_range(0, 2047)) - 1024);
            6:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            7:          v = 16'h0000;
            default:    v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic pcc_pkg::in_word_t random_word();
        pcc_pkg::in_word_t w;
        w.op      = pcc_pkg::op_t'($urandom_range(0, 1));
        w.coord_x = random_coord();
        w.coord_y = random_coord();
        case ($urandom_range(0, 7))
            0:       w.radius_in = 15'($urandom_range(0, 300));
            1:       w.radius_in = ($urandom_range(0, 1) != 0) ? 15'h7FFF : 15'h0000;
            default: w.radius_in = 15'($urandom);
        endcase
        // angles near quadrant boundaries hit the pre-rotation decision
        if ($urandom_range(0, 3) == 0)
            w.angle_in = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
        else
            w.angle_in = 16'($urandom);
        return w;
    endfunction

    task automatic issue_word(input pcc_pkg::in_word_t w, input pcc_pkg::out_word_t res,
                              input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        operand <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(res);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(input pcc_pkg::out_word_t got);
        pcc_pkg::out_word_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected word: r=%0d a=%0d x=%0d y=%0d", got.radius_out,
                         got.angle_out, $signed(got.x_out), $signed(got.y_out));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.radius_out !== want.radius_out || got.angle_out !== want.angle_out ||
                got.x_out !== want.x_out || got.y_out !== want.y_out)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch at %0t: exp r/a/x/y=%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $time, want.radius_out, want.angle_out, $signed(want.x_out),
                             $signed(want.y_out), got.radius_out, got.angle_out,
                             $signed(got.x_out), $signed(got.y_out));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            check_result(result);
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        pcc_pkg::out_word_t want;
        int                 idle;
        mismatch_count = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        operand <= '0;
        plan = '{
            row(pcc_pkg::OP_TO_POLAR, 16'h0000, 16'h0000, 15'h0000, 16'h0000, 1'b1, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h7FFF, 16'h0000, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h8000, 16'h0000, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h0000, 16'h7FFF, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h0000, 16'h8000, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h8000, 16'h8000, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h7FFF, 16'h7FFF, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'hFFFF, 16'h0000, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'hFF00, 16'h0001, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h0001, 16'h0001, 15'h0000, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_POLAR, 16'h0100, 16'h0100, 15'h7FFF, 16'hFFFF, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h0000, 16'h1234, 1'b1,
                {16'h0000, 16'h1234, 16'h0000, 16'h0000}),
            row(pcc_pkg::OP_TO_RECT,  16'hFFFF, 16'h8000, 15'h0000, 16'hFFFF, 1'b1,
                {16'h0000, 16'hFFFF, 16'h0000, 16'h0000}),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'h0000, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'h4000, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'h4001, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'h8000, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'hBFFF, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'hC000, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0000, 16'h0000, 15'h7FFF, 16'hFFFF, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'h0100, 16'hFF00, 15'h0100, 16'h6000, 1'b0, '0),
            row(pcc_pkg::OP_TO_RECT,  16'hFFFF, 16'hFFFF, 15'h03E8, 16'h1000, 1'b0, '0)
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            want = plan[i].typed ? plan[i].res : convert_word(plan[i].stim);
            issue_word(plan[i].stim, want, IDLE_PCT);
        end
        drain_pipeline();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pcc_pkg::in_word_t w;
            w = random_word();
            if (i == 900)
                drain_pipeline();
            idle = (i >= 500 && i < 800) ? 0 : IDLE_PCT;
            issue_word(w, convert_word(w), idle);
        end
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
